// ----- hw/rtl/srnt_pkg.sv -----
// Shared types and constants for the split/redirect node table.
// Holds sizes, pointer encoding, opcodes, status codes and sequencer states.
// No dependencies.
`default_nettype none

package srnt_pkg;

  // Table size is tied to the 10-bit node index fields of the stream.
  localparam int unsigned IdxW         = 10;
  localparam int unsigned NodeCapacity = 1 << IdxW;
  localparam int unsigned CntW         = IdxW + 1;
  // A child pointer carries one extra top bit that marks "no child".
  localparam int unsigned PtrW         = IdxW + 1;
  localparam logic [PtrW-1:0] PtrNone  = {1'b1, {IdxW{1'b0}}};

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [1:0] {
    OpSplit    = 2'd0,
    OpRedirect = 2'd1,
    OpGetChild = 2'd2,
    OpInspect  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatRange    = 3'd1,
    StatNotRoot  = 3'd2,
    StatNotSplit = 3'd3,
    StatFull     = 3'd4,
    StatSameNode = 3'd5
  } status_e;

  typedef enum logic [8:0] {
    StClear = 9'b000000001,
    StIdle  = 9'b000000010,
    StEval  = 9'b000000100,
    StTake  = 9'b000001000,
    StPop   = 9'b000010000,
    StLink  = 9'b000100000,
    StScan  = 9'b001000000,
    StPush  = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/split_redirect_node_table.sv -----
// Split/redirect node table: node memory, free-index stack and the sequencer.
// Depends on srnt_pkg for sizes, opcodes, status codes and state encoding.
`default_nettype none

// The block keeps a table of 1024 nodes, each with a first and a second child
// pointer, and a last-in first-out stack of freed node indices. One input beat
// carries one command and produces exactly one result beat. After reset the
// block runs a clearing pass that marks every child pointer as empty; input
// is not accepted during that pass, while the initial_nodes register can be
// written at any time the block is idle. Inspect, get child and any command
// that fails its checks go from acceptance through the evaluation state to
// the done state. A split that passes its checks then takes one child index
// at a time, popped from the free stack or fresh, and links both into the
// node; a redirect that passes its checks scans the node memory through its
// single read port, one entry per cycle, writing each updated entry back in
// the cycle after its read. The finished result sits in an output register,
// so the next command can be accepted while the previous result still waits
// to be taken. Only one command is worked on at a time.
module split_redirect_node_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration: initial_nodes.
  input  wire logic                           cfg_we_i,
  input  wire logic [srnt_pkg::CntW-1:0]      cfg_wdata_i,
  // Command stream.
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0 up: opcode[1:0], node_a[11:2], node_b[21:12],
  // pick_second[22], zero fill[23].
  input  wire logic [srnt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Result stream.
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // Fields from bit 0 up: status[2:0], new_first[12:3], new_second[22:13],
  // child_index[32:23], is_root[33], is_split[34], zero fill[39:35].
  output logic [srnt_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  localparam int unsigned IdxW = srnt_pkg::IdxW;
  localparam int unsigned CntW = srnt_pkg::CntW;
  localparam int unsigned PtrW = srnt_pkg::PtrW;
  localparam logic [CntW-1:0] Cap = CntW'(srnt_pkg::NodeCapacity);

  // Node memory entry: {second_child, first_child}.
  logic [2*PtrW-1:0] node_mem [srnt_pkg::NodeCapacity];
  logic [IdxW-1:0]   stack_mem [srnt_pkg::NodeCapacity];

  srnt_pkg::state_e  state_q, state_d;
  srnt_pkg::opcode_e op_q, op_d;
  logic [IdxW-1:0]   a_q, a_d, b_q, b_d;
  logic              pick_q, pick_d;
  logic [CntW-1:0]   init_q, init_d;
  logic [CntW-1:0]   free_cnt_q, free_cnt_d;
  logic [CntW-1:0]   grown_q, grown_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_addr_q, pend_addr_d;
  logic              sel_q, sel_d;

  // Result being built, then the output register.
  srnt_pkg::status_e res_status_q, res_status_d;
  logic [IdxW-1:0]   res_nf_q, res_nf_d, res_ns_q, res_ns_d, res_ch_q, res_ch_d;
  logic              res_root_q, res_root_d, res_split_q, res_split_d;
  logic              out_valid_q, out_valid_d;
  logic [srnt_pkg::OutDataW-1:0] out_data_q, out_data_d;

  // Memory ports.
  logic [IdxW-1:0]   node_raddr;
  logic [2*PtrW-1:0] node_rd_q;
  logic              node_we;
  logic [IdxW-1:0]   node_waddr;
  logic [2*PtrW-1:0] node_wdata;
  logic [IdxW-1:0]   stack_raddr;
  logic [IdxW-1:0]   stack_rd_q;
  logic              stack_we;

  // Table size and derived checks.
  logic [CntW-1:0]   base_c;
  logic [CntW:0]     sum_c;
  logic [CntW-1:0]   size_c;
  logic [CntW:0]     room_c;
  logic [PtrW-1:0]   first_c, second_c, first_new, second_new;
  logic              a_ok, is_root, is_split;
  logic              in_accept, out_free;
  logic [CntW-1:0]   cnt_dec;

  assign base_c  = (init_q > Cap) ? Cap : init_q;
  assign sum_c   = {1'b0, base_c} + {1'b0, grown_q};
  assign size_c  = (sum_c > {1'b0, Cap}) ? Cap : sum_c[CntW-1:0];
  assign room_c  = {1'b0, free_cnt_q} + ({1'b0, Cap} - {1'b0, size_c});

  assign first_c  = node_rd_q[PtrW-1:0];
  assign second_c = node_rd_q[2*PtrW-1:PtrW];
  assign a_ok     = {1'b0, a_q} < size_c;
  assign is_root  = a_ok & first_c[PtrW-1] & second_c[PtrW-1];
  assign is_split = a_ok & ~first_c[PtrW-1] & ~second_c[PtrW-1];

  // Redirect rewrite of one scanned entry.
  assign first_new  = (first_c == {1'b0, a_q}) ? {1'b0, b_q} : first_c;
  assign second_new = (second_c == {1'b0, a_q}) ? {1'b0, b_q} : second_c;

  assign cnt_dec     = free_cnt_q - CntW'(1);
  assign stack_raddr = cnt_dec[IdxW-1:0];

  assign s_axis_tready_o = (state_q == srnt_pkg::StIdle);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    pick_d       = pick_q;
    init_d       = cfg_we_i ? cfg_wdata_i : init_q;
    free_cnt_d   = free_cnt_q;
    grown_d      = grown_q;
    scan_d       = scan_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    sel_d        = sel_q;
    res_status_d = res_status_q;
    res_nf_d     = res_nf_q;
    res_ns_d     = res_ns_q;
    res_ch_d     = res_ch_q;
    res_root_d   = res_root_q;
    res_split_d  = res_split_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_data_d   = out_data_q;
    node_raddr   = s_axis_tdata_i[IdxW+1:2];
    node_we      = 1'b0;
    node_waddr   = a_q;
    node_wdata   = {srnt_pkg::PtrNone, srnt_pkg::PtrNone};
    stack_we     = 1'b0;

    unique case (state_q)
      srnt_pkg::StClear: begin
        node_we    = 1'b1;
        node_waddr = scan_q[IdxW-1:0];
        scan_d     = scan_q + CntW'(1);
        if (scan_q[IdxW-1:0] == {IdxW{1'b1}}) begin
          state_d = srnt_pkg::StIdle;
        end
      end

      srnt_pkg::StIdle: begin
        if (in_accept) begin
          op_d         = srnt_pkg::opcode_e'(s_axis_tdata_i[1:0]);
          a_d          = s_axis_tdata_i[IdxW+1:2];
          b_d          = s_axis_tdata_i[2*IdxW+1:IdxW+2];
          pick_d       = s_axis_tdata_i[2*IdxW+2];
          res_status_d = srnt_pkg::StatOk;
          res_nf_d     = '0;
          res_ns_d     = '0;
          res_ch_d     = '0;
          state_d      = srnt_pkg::StEval;
        end
      end

      srnt_pkg::StEval: begin
        res_root_d  = is_root;
        res_split_d = is_split;
        state_d     = srnt_pkg::StDone;
        if (!a_ok) begin
          res_status_d = srnt_pkg::StatRange;
        end else begin
          unique case (op_q)
            srnt_pkg::OpSplit: begin
              if (!is_root) begin
                res_status_d = srnt_pkg::StatNotRoot;
              end else if (room_c < (CntW+1)'(2)) begin
                res_status_d = srnt_pkg::StatFull;
              end else begin
                sel_d   = 1'b0;
                state_d = srnt_pkg::StTake;
              end
            end
            srnt_pkg::OpRedirect: begin
              if ({1'b0, b_q} >= size_c) begin
                res_status_d = srnt_pkg::StatRange;
              end else if (!is_root) begin
                res_status_d = srnt_pkg::StatNotRoot;
              end else if (a_q == b_q) begin
                res_status_d = srnt_pkg::StatSameNode;
              end else begin
                scan_d  = '0;
                pend_d  = 1'b0;
                state_d = srnt_pkg::StScan;
              end
            end
            srnt_pkg::OpGetChild: begin
              if (!is_split) begin
                res_status_d = srnt_pkg::StatNotSplit;
              end else begin
                res_ch_d = pick_q ? second_c[IdxW-1:0] : first_c[IdxW-1:0];
              end
            end
            srnt_pkg::OpInspect: begin
            end
            default: begin
            end
          endcase
        end
      end

      // Take one child index: pop the free stack, or hand out a fresh index.
      srnt_pkg::StTake: begin
        if (free_cnt_q != '0) begin
          free_cnt_d = cnt_dec;
          state_d    = srnt_pkg::StPop;
        end else begin
          grown_d = grown_q + CntW'(1);
          if (sel_q) begin
            res_ns_d = size_c[IdxW-1:0];
            state_d  = srnt_pkg::StLink;
          end else begin
            res_nf_d = size_c[IdxW-1:0];
          end
          sel_d = ~sel_q;
        end
      end

      srnt_pkg::StPop: begin
        if (sel_q) begin
          res_ns_d = stack_rd_q;
          state_d  = srnt_pkg::StLink;
        end else begin
          res_nf_d = stack_rd_q;
          state_d  = srnt_pkg::StTake;
        end
        sel_d = ~sel_q;
      end

      srnt_pkg::StLink: begin
        node_we    = 1'b1;
        node_waddr = a_q;
        node_wdata = {1'b0, res_ns_q, 1'b0, res_nf_q};
        state_d    = srnt_pkg::StDone;
      end

      // Read entry scan_q while the entry read in the previous cycle is rewritten.
      srnt_pkg::StScan: begin
        node_raddr = scan_q[IdxW-1:0];
        node_we    = pend_q;
        node_waddr = pend_addr_q;
        node_wdata = {second_new, first_new};
        if (scan_q < size_c) begin
          pend_d      = 1'b1;
          pend_addr_d = scan_q[IdxW-1:0];
          scan_d      = scan_q + CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = srnt_pkg::StPush;
          end
        end
      end

      // A push onto a full stack is dropped.
      srnt_pkg::StPush: begin
        if (free_cnt_q < Cap) begin
          stack_we   = 1'b1;
          free_cnt_d = free_cnt_q + CntW'(1);
        end
        state_d = srnt_pkg::StDone;
      end

      srnt_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'b0, res_split_q, res_root_q, res_ch_q, res_ns_q, res_nf_q,
                         res_status_q};
          state_d     = srnt_pkg::StIdle;
        end
      end

      default: begin
        state_d = srnt_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srnt_pkg::StClear;
      init_q      <= '0;
      free_cnt_q  <= '0;
      grown_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      free_cnt_q  <= free_cnt_d;
      grown_q     <= grown_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    a_q          <= a_d;
    b_q          <= b_d;
    pick_q       <= pick_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_nf_q     <= res_nf_d;
    res_ns_q     <= res_ns_d;
    res_ch_q     <= res_ch_d;
    res_root_q   <= res_root_d;
    res_split_q  <= res_split_d;
    out_data_q   <= out_data_d;
  end

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_raddr];
  end

  // Free stack: pushes write at the count, the read always looks at the top.
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[free_cnt_q[IdxW-1:0]] <= a_q;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

endmodule

`default_nettype wire
